/* rtl/hrcc_pkg.sv */
// Package for the HTTP response completeness check: limits, parse phases
// and match-string lookup functions. No dependencies.
`default_nettype none
package hrcc_pkg;
  localparam int unsigned MaxObject = 102400;
  localparam int unsigned LineMax = 8192;

  typedef enum logic [3:0] {
    PH_STATUS   = 4'd0,
    PH_HEADER   = 4'd1,
    PH_BODY     = 4'd2,
    PH_CSIZE    = 4'd3,
    PH_CEXT     = 4'd4,
    PH_CSIZE_LF = 4'd5,
    PH_CDATA    = 4'd6,
    PH_CDATA_CR = 4'd7,
    PH_CDATA_LF = 4'd8,
    PH_TRAILER  = 4'd9,
    PH_DONE     = 4'd10
  } phase_e;

  function automatic logic [7:0] status_char(input logic [4:0] p);
    logic [7:0] r;
    case (p)
      5'd0: r = "H";  5'd1: r = "T";  5'd2: r = "T";  5'd3: r = "P";
      5'd4: r = "/";  5'd5: r = "1";  5'd6: r = ".";  5'd7: r = "0";
      5'd8: r = " ";  5'd9: r = "2";  5'd10: r = "0"; 5'd11: r = "0";
      5'd12: r = " ";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] p);
    logic [7:0] r;
    case (p)
      5'd0: r = "t";  5'd1: r = "r";  5'd2: r = "a";  5'd3: r = "n";
      5'd4: r = "s";  5'd5: r = "f";  5'd6: r = "e";  5'd7: r = "r";
      5'd8: r = "-";  5'd9: r = "e";  5'd10: r = "n"; 5'd11: r = "c";
      5'd12: r = "o"; 5'd13: r = "d"; 5'd14: r = "i"; 5'd15: r = "n";
      5'd16: r = "g";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cl_char(input logic [4:0] p);
    logic [7:0] r;
    case (p)
      5'd0: r = "c";  5'd1: r = "o";  5'd2: r = "n";  5'd3: r = "t";
      5'd4: r = "e";  5'd5: r = "n";  5'd6: r = "t";  5'd7: r = "-";
      5'd8: r = "l";  5'd9: r = "e";  5'd10: r = "n"; 5'd11: r = "g";
      5'd12: r = "t"; 5'd13: r = "h";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] chunked_char(input logic [4:0] p);
    logic [7:0] r;
    case (p)
      5'd0: r = "c"; 5'd1: r = "h"; 5'd2: r = "u"; 5'd3: r = "n";
      5'd4: r = "k"; 5'd5: r = "e"; 5'd6: r = "d";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction
endpackage
`default_nettype wire

/* rtl/http_response_completeness_check_core.sv */
// HTTP response completeness check, top level.
// Depends on hrcc_pkg for limits, phases and match strings.
//
// Usage: the response is fed one byte per input beat on data_byte_i, with
// last_byte_i set on its final byte. Beats without last_byte_i produce no
// output. The beat that carries last_byte_i produces exactly one output
// beat on cacheable_o: 1 if the response had an "HTTP/1.0 200 " or
// "HTTP/1.1 200 " status line, well-formed headers, a terminating blank
// line and a body that agrees with its Content-Length or chunked framing;
// 0 otherwise. The parse state advances in the same cycle a byte is taken,
// so one byte is accepted every cycle while in_ready_o is high; the verdict
// is captured in the output register as the final byte is taken. The single
// output register sets the rate: in_ready_o is high whenever that register
// is empty or being drained in the same cycle, so a stalled receiver only
// holds input once a verdict is waiting. After each verdict the parser
// returns to its reset state, ready for the next response. Asynchronous
// reset clears the parser and empties the output register.
`default_nettype none
module http_response_completeness_check_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            cacheable_o
);
  import hrcc_pkg::*;

  localparam int unsigned LenW = 17;
  localparam int unsigned CntW = 18;
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxObject);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxObject);
  localparam logic [13:0] LineLim = 14'(LineMax);

  phase_e      phase_q, phase_d;
  logic        fail_q, fail_d;
  logic [4:0]  mpos_q, mpos_d;
  logic [13:0] llen_q, llen_d;
  logic        crp_q, crp_d;
  logic [1:0]  cand_q, cand_d;
  logic [3:0]  vsub_q, vsub_d;
  logic        chk_q, chk_d;
  logic        lens_q, lens_d;
  logic [LenW-1:0] dlen_q, dlen_d;
  logic [CntW-1:0] bcnt_q, bcnt_d;
  logic [LenW-1:0] crem_q, crem_d;
  logic        colon_q, colon_d;
  logic        ov_q, res_q, verdict;

  logic accept;
  assign in_ready_o  = !ov_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign cacheable_o = res_q;

  always_comb begin
    logic [7:0] c, l;
    logic blank, digit, eol, do_content, vrun;
    logic [3:0] hv;
    logic hvalid;
    logic [21:0] acc;
    c = data_byte_i;
    l = to_lower(c);
    phase_d = phase_q; fail_d = fail_q; mpos_d = mpos_q; llen_d = llen_q;
    crp_d = crp_q; cand_d = cand_q; vsub_d = vsub_q; chk_d = chk_q;
    lens_d = lens_q; dlen_d = dlen_q; bcnt_d = bcnt_q; crem_d = crem_q;
    colon_d = colon_q;
    eol = 1'b0; do_content = 1'b0;
    blank = 1'b0; digit = 1'b0; vrun = 1'b0; acc = '0;
    hvalid = 1'b0; hv = '0;
    if (!fail_q) begin
      case (phase_q)
        PH_STATUS, PH_HEADER: begin
          // A pending CR is either the end of line or a content byte
          // processed before the current byte; the latter is chained here.
          if (crp_q) begin
            crp_d = 1'b0;
            if (c == 8'h0a) eol = 1'b1;
            else begin
              if (llen_q >= LineLim - 14'd1) begin
                fail_d = 1'b1;
                llen_d = LineLim;
              end else begin
                llen_d = llen_q + 14'd1;
                if (phase_q == PH_STATUS) begin
                  if (mpos_q < 5'd13) begin
                    if (8'h0d != status_char(mpos_q)) fail_d = 1'b1;
                    mpos_d = mpos_q + 5'd1;
                  end
                end else if (!colon_q) begin
                  if (mpos_q >= 5'd17 || 8'h0d != te_char(mpos_q)) cand_d[0] = 1'b0;
                  if (mpos_q >= 5'd14 || 8'h0d != cl_char(mpos_q)) cand_d[1] = 1'b0;
                  if (mpos_q < 5'd31) mpos_d = mpos_q + 5'd1;
                end else begin
                  case (vsub_q)
                    4'd1: begin vsub_d = 4'd2; fail_d = 1'b1; end
                    4'd2: fail_d = 1'b1;
                    4'd3, 4'd4, 4'd5, 4'd6: fail_d = 1'b1;
                    default: ;
                  endcase
                end
              end
            end
          end
          if (!eol && !fail_d) begin
            if (c == 8'h0d) crp_d = 1'b1;
            else do_content = 1'b1;
          end
          if (eol) begin
            if (phase_q == PH_STATUS) begin
              if (mpos_q < 5'd13) fail_d = 1'b1;
              phase_d = PH_HEADER;
            end else if (llen_q == 14'd0) begin
              if (chk_q && lens_q) fail_d = 1'b1;
              phase_d = chk_q ? PH_CSIZE : PH_BODY;
              bcnt_d = '0;
              crem_d = '0;
            end else begin
              if (!colon_q) fail_d = 1'b1;
              if (vsub_q == 4'd1 || vsub_q == 4'd4 ||
                  (vsub_q == 4'd2 && mpos_q < 5'd7)) fail_d = 1'b1;
            end
            llen_d = '0; colon_d = 1'b0; mpos_d = '0; cand_d = 2'b11;
            vsub_d = '0;
          end
          if (do_content) begin
            // Content byte, evaluated on the state after any pending CR.
            if (llen_d >= LineLim - 14'd1 || c == 8'h00) begin
              fail_d = 1'b1;
              if (llen_d < LineLim) llen_d = llen_d + 14'd1;
            end else begin
              llen_d = llen_d + 14'd1;
              if (phase_q == PH_STATUS) begin
                if (mpos_d < 5'd13) begin
                  if (!(c == status_char(mpos_d) || (mpos_d == 5'd7 && c == "1")))
                    fail_d = 1'b1;
                  mpos_d = mpos_d + 5'd1;
                end
              end else if (!colon_d) begin
                if (c == ":") begin
                  colon_d = 1'b1;
                  if (cand_d[0] && mpos_d == 5'd17) begin
                    if (chk_q) fail_d = 1'b1;
                    chk_d = 1'b1; vsub_d = 4'd1;
                  end else if (cand_d[1] && mpos_d == 5'd14) begin
                    if (lens_q) fail_d = 1'b1;
                    lens_d = 1'b1; dlen_d = '0; vsub_d = 4'd4;
                  end
                  mpos_d = '0;
                end else begin
                  if (mpos_d >= 5'd17 || l != te_char(mpos_d)) cand_d[0] = 1'b0;
                  if (mpos_d >= 5'd14 || l != cl_char(mpos_d)) cand_d[1] = 1'b0;
                  if (mpos_d < 5'd31) mpos_d = mpos_d + 5'd1;
                end
              end else begin
                blank = (c == " ") || (c == 8'h09);
                digit = (c >= "0") && (c <= "9");
                acc = 22'(dlen_d) * 22'd10 + 22'(c - "0");
                vrun = 1'b0;
                case (vsub_d)
                  4'd1: if (!blank) begin vsub_d = 4'd2; mpos_d = '0; vrun = 1'b1; end
                  4'd2: vrun = 1'b1;
                  4'd3, 4'd6: if (!blank) fail_d = 1'b1;
                  4'd4: begin
                    if (!blank) begin
                      if (!digit) fail_d = 1'b1;
                      else begin
                        vsub_d = 4'd5;
                        if (acc > 22'(MaxObject)) begin fail_d = 1'b1; dlen_d = MaxLen; end
                        else dlen_d = LenW'(acc);
                      end
                    end
                  end
                  4'd5: begin
                    if (digit) begin
                      if (acc > 22'(MaxObject)) begin fail_d = 1'b1; dlen_d = MaxLen; end
                      else dlen_d = LenW'(acc);
                    end else if (blank) vsub_d = 4'd6;
                    else fail_d = 1'b1;
                  end
                  default: ;
                endcase
                if (vrun) begin
                  if (mpos_d < 5'd7) begin
                    if (l != chunked_char(mpos_d)) fail_d = 1'b1;
                    else mpos_d = mpos_d + 5'd1;
                  end else if (blank) vsub_d = 4'd3;
                  else fail_d = 1'b1;
                end
              end
            end
          end
        end
        PH_BODY: if (bcnt_q <= MaxCnt) bcnt_d = bcnt_q + 1'b1;
        PH_CSIZE: begin
          if (c >= "0" && c <= "9") begin hvalid = 1'b1; hv = c[3:0]; end
          else if (l >= "a" && l <= "f") begin hvalid = 1'b1; hv = 4'(l - "a" + 8'd10); end
          if (hvalid) begin
            acc = {1'b0, crem_q, 4'(0)} | 22'(hv);
            if (acc > 22'(MaxObject)) begin fail_d = 1'b1; crem_d = MaxLen; end
            else crem_d = LenW'(acc);
            mpos_d = 5'd1;
          end else if (mpos_q == 5'd0) fail_d = 1'b1;
          else if (c == ";") phase_d = PH_CEXT;
          else if (c == 8'h0d) phase_d = PH_CSIZE_LF;
          else fail_d = 1'b1;
        end
        PH_CEXT: if (c == 8'h0d) phase_d = PH_CSIZE_LF;
        PH_CSIZE_LF: begin
          if (c != 8'h0a) fail_d = 1'b1;
          else if (crem_q == '0) begin
            phase_d = PH_TRAILER;
            llen_d = '0; colon_d = 1'b0; mpos_d = '0; cand_d = 2'b11;
            vsub_d = '0; crp_d = 1'b0;
          end else phase_d = PH_CDATA;
        end
        PH_CDATA: begin
          if (crem_q != '0) crem_d = crem_q - 1'b1;
          if (crem_q <= LenW'(1)) phase_d = PH_CDATA_CR;
        end
        PH_CDATA_CR: if (c == 8'h0d) phase_d = PH_CDATA_LF; else fail_d = 1'b1;
        PH_CDATA_LF: begin
          if (c == 8'h0a) begin phase_d = PH_CSIZE; crem_d = '0; mpos_d = '0; end
          else fail_d = 1'b1;
        end
        PH_TRAILER: begin
          if (crp_q && c == 8'h0a) begin
            crp_d = 1'b0;
            if (llen_q == 14'd0) phase_d = PH_DONE;
            else if (!colon_q) fail_d = 1'b1;
            else begin
              llen_d = '0; colon_d = 1'b0; mpos_d = '0; cand_d = 2'b11;
              vsub_d = '0;
            end
          end else begin
            if (crp_q) llen_d = 14'd1;
            if (c == 8'h0d) crp_d = 1'b1;
            else begin
              crp_d = 1'b0;
              llen_d = 14'd1;
              if (c == ":") colon_d = 1'b1;
            end
          end
        end
        default: fail_d = 1'b1;
      endcase
    end
    verdict = 1'b0;
    if (!fail_d) begin
      if (phase_d == PH_BODY) verdict = !lens_d || (bcnt_d == CntW'(dlen_d));
      else if (phase_d == PH_DONE) verdict = 1'b1;
    end
    // Return to reset state after the final byte.
    if (last_byte_i) begin
      phase_d = PH_STATUS; fail_d = 1'b0; crp_d = 1'b0; chk_d = 1'b0;
      lens_d = 1'b0; dlen_d = '0; bcnt_d = '0; crem_d = '0;
      llen_d = '0; colon_d = 1'b0; mpos_d = '0; cand_d = 2'b11; vsub_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STATUS; fail_q <= 1'b0; mpos_q <= '0; llen_q <= '0;
      crp_q <= 1'b0; cand_q <= 2'b11; vsub_q <= '0; chk_q <= 1'b0;
      lens_q <= 1'b0; dlen_q <= '0; bcnt_q <= '0; crem_q <= '0;
      colon_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d; fail_q <= fail_d; mpos_q <= mpos_d; llen_q <= llen_d;
        crp_q <= crp_d; cand_q <= cand_d; vsub_q <= vsub_d; chk_q <= chk_d;
        lens_q <= lens_d; dlen_q <= dlen_d; bcnt_q <= bcnt_d; crem_q <= crem_d;
        colon_q <= colon_d;
      end
      if (accept && last_byte_i) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) res_q <= verdict;
  end
endmodule
`default_nettype wire
